// ===== sv/b64u_pkg.sv =====
package b64u_pkg;

    localparam logic [6:0] CodeInvalid = 7'd64;
    localparam logic [6:0] CodeSlash   = 7'd63;
    localparam logic [6:0] CodePlus    = 7'd62;
    localparam logic [7:0] ChSlash     = 8'h2F;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChPlus      = 8'h2B;

    // Quad assembly state for one string
    typedef struct packed {
        logic [2:0][6:0] sext;
        logic [1:0]      pos;
        logic            bs;
        logic            err;
    } state_t;

    // Results caused by one input beat: up to three bytes, then the end result on a string's last beat
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [2:0]      byte_en;
        logic            eos;
        logic            err;
    } bundle_t;

    typedef struct packed {
        state_t          st;
        logic [2:0][7:0] bytes;
        logic [2:0]      en;
    } feed_t;

    function automatic logic [6:0] sextet_of(logic [7:0] ch);
        logic [6:0] code;
        code = CodeInvalid;
        if (ch inside {[8'h41:8'h5A]}) begin
            code = 7'(ch - 8'h41);
        end else if (ch inside {[8'h61:8'h7A]}) begin
            code = 7'(ch - 8'h61 + 8'd26);
        end else if (ch inside {[8'h30:8'h39]}) begin
            code = 7'(ch - 8'h30 + 8'd52);
        end else if (ch == ChPlus) begin
            code = CodePlus;
        end else if (ch == ChSlash) begin
            code = CodeSlash;
        end
        return code;
    endfunction

    // Push one sextet code into the quad; on the fourth, decode the quad.
    function automatic feed_t feed(state_t s, logic [6:0] code);
        feed_t      r;
        logic [6:0] a;
        logic [6:0] b;
        logic [6:0] c;
        r.st    = s;
        r.bytes = '0;
        r.en    = '0;
        a       = s.sext[0];
        b       = s.sext[1];
        c       = s.sext[2];
        if (s.pos != 2'd3) begin
            r.st.sext[s.pos] = code;
            r.st.pos         = s.pos + 2'd1;
        end else begin
            r.st.pos = 2'd0;
            if (!s.err) begin
                if (a == CodeInvalid || b == CodeInvalid) begin
                    r.st.err = 1'b1;
                end else begin
                    r.en[0]    = 1'b1;
                    r.en[1]    = (c != CodeInvalid);
                    r.en[2]    = (code != CodeInvalid);
                    r.bytes[0] = {a[5:0], b[5:4]};
                    r.bytes[1] = {b[3:0], c[5:2]};
                    // c invalid leaves c[1:0] = 0, so the byte is d itself
                    r.bytes[2] = {c[1:0], code[5:0]};
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/b64u_step.sv =====
module b64u_step
    import b64u_pkg::*;
(
    input  state_t     state,
    input  logic [7:0] char_in,
    input  logic       has_char,
    input  logic       is_last,
    output state_t     state_next,
    output bundle_t    bundle
);

    always_comb
    begin
        logic       fv0;
        logic       fv1;
        logic [6:0] c0;
        logic [6:0] c1;
        logic       bs;
        feed_t      f0;
        feed_t      f1;
        state_t     s1;
        state_t     s2;

        fv0 = 1'b0;
        fv1 = 1'b0;
        c0  = CodeInvalid;
        c1  = CodeInvalid;
        bs  = state.bs;

        // Up to two sextet codes per beat: a stale backslash, then the char
        if (has_char) begin
            if (state.bs) begin
                bs  = 1'b0;
                fv0 = 1'b1;
                if (char_in == ChSlash) begin
                    c0 = CodeSlash;
                end else begin
                    c0 = CodeInvalid;
                    if (char_in == ChBackslash) begin
                        bs = 1'b1;
                    end else begin
                        fv1 = 1'b1;
                        c1  = sextet_of(char_in);
                    end
                end
            end else if (char_in == ChBackslash) begin
                bs = 1'b1;
            end else begin
                fv0 = 1'b1;
                c0  = sextet_of(char_in);
            end
        end

        // Backslash left pending at the end goes in as an invalid char
        if (is_last && bs) begin
            bs = 1'b0;
            if (fv0) begin
                fv1 = 1'b1;
                c1  = CodeInvalid;
            end else begin
                fv0 = 1'b1;
                c0  = CodeInvalid;
            end
        end

        f0 = feed(state, c0);
        s1 = fv0 ? f0.st : state;
        f1 = feed(s1, c1);
        s2 = fv1 ? f1.st : s1;
        s2.bs = bs;

        // At most one quad completes per beat
        bundle.byte_en = (fv0 ? f0.en : 3'b000) | (fv1 ? f1.en : 3'b000);
        bundle.bytes   = (fv0 && (|f0.en)) ? f0.bytes : f1.bytes;
        bundle.eos     = is_last;
        bundle.err     = s2.err;

        state_next = is_last ? '0 : s2;
    end

endmodule

// ===== sv/b64u_serializer.sv =====
module b64u_serializer
    import b64u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  bundle_t    bundle,
    output logic       take_ok,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       end_of_string,
    output logic       decode_error
);

    bundle_t    bundle_reg;
    logic [3:0] pend_reg;
    logic [3:0] pend_next;
    logic       out_fire;
    logic       last_beat;

    assign result_valid = |pend_reg;
    assign out_fire     = result_valid && result_ready;
    assign last_beat    = $onehot(pend_reg);
    // Next beat can enter while the last pending result leaves
    assign take_ok      = (pend_reg == 4'b0000) || (last_beat && result_ready);

    always_comb
    begin
        pend_next = pend_reg;
        if (out_fire) begin
            pend_next = pend_reg & (pend_reg - 4'd1);
        end
        if (load) begin
            pend_next = {bundle.eos, bundle.byte_en};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= 4'b0000;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            bundle_reg <= bundle;
        end
    end

    always_comb
    begin
        data_byte     = 8'h00;
        byte_valid    = |pend_reg[2:0];
        end_of_string = 1'b0;
        decode_error  = 1'b0;
        if (pend_reg[0]) begin
            data_byte = bundle_reg.bytes[0];
        end else if (pend_reg[1]) begin
            data_byte = bundle_reg.bytes[1];
        end else if (pend_reg[2]) begin
            data_byte = bundle_reg.bytes[2];
        end else if (pend_reg[3]) begin
            end_of_string = 1'b1;
            decode_error  = bundle_reg.err;
        end
    end

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load && (bundle.eos || (|bundle.byte_en)) |=> result_valid)
        else $error("loaded results not presented");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(pend_reg) > 1) |-> !take_ok)
        else $error("new beat taken while results still queued");

    a_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !last_beat |=>
            ($countones(pend_reg) == $countones($past(pend_reg)) - 1))
        else $error("drain step lost or repeated a result");

endmodule

// ===== sv/base64_decoder_with_slash_unescape.sv =====
// Channel | Handshake                  | Payload
// char    | char_valid / char_ready    | char_in[7:0], has_char, is_last
// result  | result_valid / result_ready| data_byte[7:0], byte_valid,
//         |                            | end_of_string, decode_error
//
// A char beat is decoded in the cycle it is accepted; its results (0 to 4)
// appear on the result port from the next cycle, one per cycle while
// result_ready is high. A beat giving at most one result allows a new
// char beat every cycle while result_ready is high; a beat giving more
// results holds char_ready low while the output drains. rst_n clears the
// quad state and drops any queued results. result_ready low stalls the
// output and, while any result is queued, the char side too.
module base64_decoder_with_slash_unescape
    import b64u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_in,
    input  logic       has_char,
    input  logic       is_last,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       end_of_string,
    output logic       decode_error
);

    state_t  state_reg;
    state_t  state_next;
    bundle_t bundle;
    logic    char_fire;

    assign char_fire = char_valid && char_ready;

    b64u_step u_step (
        .state      (state_reg),
        .char_in    (char_in),
        .has_char   (has_char),
        .is_last    (is_last),
        .state_next (state_next),
        .bundle     (bundle)
    );

    b64u_serializer u_ser (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (char_fire),
        .bundle        (bundle),
        .take_ok       (char_ready),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .end_of_string (end_of_string),
        .decode_error  (decode_error)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (char_fire) begin
            state_reg <= state_next;
        end
    end

    a_string_restart: assert property (@(posedge clk) disable iff (!rst_n)
        char_fire && is_last |=> (state_reg == '0))
        else $error("quad state not cleared after end of string");

endmodule

// ===== sim/b64u_decode_checker.sv =====
module b64u_decode_checker
    import b64u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [7:0]  char_in,
    input  logic        has_char,
    input  logic        is_last,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_string,
    input  logic        decode_error,
    output int unsigned outstanding,
    output int unsigned mismatches,
    output int unsigned results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       is_byte;
        logic       eos;
        logic       err;
    } decoded_t;

    decoded_t   decoded_due[$];
    logic [6:0] quad_codes [0:2];
    logic [1:0] quad_count;
    logic       escape_open;
    logic       string_error;

    function automatic logic [6:0] alphabet_code(input logic [7:0] ch);
        if (ch >= 8'h41 && ch <= 8'h5A)          // A..Z
            return 7'(ch - 8'h41);
        else if (ch >= 8'h61 && ch <= 8'h7A)     // a..z
            return 7'(ch - 8'h61 + 8'd26);
        else if (ch >= 8'h30 && ch <= 8'h39)     // 0..9
            return 7'(ch - 8'h30 + 8'd52);
        else if (ch == ChPlus)
            return CodePlus;
        else if (ch == ChSlash)
            return CodeSlash;
        return CodeInvalid;
    endfunction

    task automatic clear_string();
        quad_codes[0] = '0;
        quad_codes[1] = '0;
        quad_codes[2] = '0;
        quad_count    = '0;
        escape_open   = 1'b0;
        string_error  = 1'b0;
    endtask

    task automatic queue_result(input decoded_t r);
        decoded_due.insert(decoded_due.size(), r);
    endtask

    task automatic push_decoded(input logic [7:0] value);
        decoded_t r;
        r.data    = value;
        r.is_byte = 1'b1;
        r.eos     = 1'b0;
        r.err     = 1'b0;
        queue_result(r);
    endtask

    // Collect one sextet; the fourth one closes the quad and yields its bytes.
    task automatic take_sextet(input logic [6:0] code);
        int unsigned sa;
        int unsigned sb;
        int unsigned sc;
        int unsigned sd;
        if (quad_count != 2'd3) begin
            quad_codes[quad_count] = code;
            quad_count = quad_count + 2'd1;
        end else begin
            quad_count = 2'd0;
            if (!string_error) begin
                sa = quad_codes[0];
                sb = quad_codes[1];
                sc = quad_codes[2];
                sd = code;
                if (sa == CodeInvalid || sb == CodeInvalid) begin
                    string_error = 1'b1;
                end else begin
                    push_decoded(8'(((sa << 2) | (sb >> 4)) & 32'hFF));
                    if (sc != CodeInvalid)
                        push_decoded(8'(((sb << 4) | (sc >> 2)) & 32'hFF));
                    // invalid third char drops out mod 256, leaving d alone
                    if (sd != CodeInvalid)
                        push_decoded(8'(((sc << 6) | sd) & 32'hFF));
                end
            end
        end
    endtask

    task automatic decode_char_beat(input logic [7:0] ch, input logic hc, input logic lst);
        logic     fresh;
        decoded_t done;
        fresh = 1'b1;
        if (hc) begin
            if (escape_open) begin
                escape_open = 1'b0;
                if (ch == ChSlash) begin
                    take_sextet(CodeSlash);
                    fresh = 1'b0;
                end else begin
                    take_sextet(CodeInvalid);
                end
            end
            if (fresh) begin
                if (ch == ChBackslash)
                    escape_open = 1'b1;
                else
                    take_sextet(alphabet_code(ch));
            end
        end
        if (lst) begin
            if (escape_open) begin
                escape_open = 1'b0;
                take_sextet(CodeInvalid);
            end
            done.data    = 8'h00;
            done.is_byte = 1'b0;
            done.eos     = 1'b1;
            done.err     = string_error;
            queue_result(done);
            clear_string();
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        decoded_t want;
        if (!rst_n) begin
            clear_string();
            decoded_due.delete();
            outstanding  <= 0;
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (result_valid && result_ready) begin
                results_seen++;
                if (decoded_due.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got %02h/%0b/%0b/%0b",
                             $time, data_byte, byte_valid, end_of_string, decode_error);
                    mismatches++;
                end else begin
                    want = decoded_due.pop_front();
                    compare_field("data_byte", want.data, data_byte);
                    compare_field("byte_valid", 8'(want.is_byte), 8'(byte_valid));
                    compare_field("end_of_string", 8'(want.eos), 8'(end_of_string));
                    compare_field("decode_error", 8'(want.err), 8'(decode_error));
                end
            end
            if (char_valid && char_ready)
                decode_char_beat(char_in, has_char, is_last);
            outstanding <= decoded_due.size();
        end
    end

endmodule

// ===== sim/base64_decoder_with_slash_unescape_tb.sv =====
module base64_decoder_with_slash_unescape_tb
    import b64u_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BEAT_TARGET  = 210;
    localparam int unsigned QUIET_FROM   = 180;
    localparam int unsigned LONG_HOLD    = 48;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned SETTLE_WAIT  = 8;
    localparam logic [7:0]  PadChar      = 8'h3D;

    typedef struct {
        logic [7:0] ch;
        logic       hc;
        logic       lst;
    } char_beat_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       char_valid   = 1'b0;
    logic       char_ready;
    logic [7:0] char_in      = 8'h00;
    logic       has_char     = 1'b0;
    logic       is_last      = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       decode_error;

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned results_seen;

    char_beat_t  line_beats[$];
    int unsigned beats_sent     = 0;
    int unsigned lines_sent     = 0;
    int unsigned tx_calm        = 0;
    int unsigned rx_calm        = 0;
    int unsigned idle_cycles    = 0;
    bit          quiet_tail     = 1'b0;
    bit          hold_request   = 1'b0;
    bit          mid_hold_done  = 1'b0;
    bit          mid_drain_done = 1'b0;

    always #2 clk = ~clk;

    base64_decoder_with_slash_unescape DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .char_in       (char_in),
        .has_char      (has_char),
        .is_last       (is_last),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .end_of_string (end_of_string),
        .decode_error  (decode_error)
    );

    b64u_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .char_in       (char_in),
        .has_char      (has_char),
        .is_last       (is_last),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .data_byte     (data_byte),
        .byte_valid    (byte_valid),
        .end_of_string (end_of_string),
        .decode_error  (decode_error),
        .outstanding   (outstanding),
        .mismatches    (mismatches),
        .results_seen  (results_seen)
    );

    // no beat on either channel for too long means the block hung
    always @(posedge clk) begin
        if (!rst_n || (char_valid && char_ready) || (result_valid && result_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, outstanding);
            $display("FAIL base64_decoder_with_slash_unescape");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random back-pressure bursts, calm stretches, long holds on request
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end else if (!quiet_tail && rx_calm == 0 && $urandom_range(0, 4) == 0) begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge clk);
            end else begin
                result_ready <= 1'b1;
                if (rx_calm != 0)
                    rx_calm--;
                else if ($urandom_range(0, 9) == 0)
                    rx_calm = $urandom_range(8, 24);
            end
        end
    end

    task automatic send_beat(input char_beat_t b);
        if (!quiet_tail && tx_calm == 0 && $urandom_range(0, 4) == 0) begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end else if (tx_calm != 0) begin
            tx_calm--;
        end else if ($urandom_range(0, 9) == 0) begin
            tx_calm = $urandom_range(8, 24);
        end
        char_valid <= 1'b1;
        char_in    <= b.ch;
        has_char   <= b.hc;
        is_last    <= b.lst;
        do @(posedge clk); while (!char_ready);
        beats_sent++;
    endtask

    task automatic pause_until_drained();
        char_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic add_beat(input logic [7:0] ch, input logic hc);
        char_beat_t b;
        b.ch  = ch;
        b.hc  = hc;
        b.lst = 1'b0;
        line_beats.insert(line_beats.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_beat(s[i], 1'b1);
    endtask

    task automatic send_line();
        char_beat_t b;
        if (line_beats.size() == 0)
            add_beat(8'($urandom_range(0, 255)), 1'b0);
        line_beats[line_beats.size() - 1].lst = 1'b1;
        while (line_beats.size() != 0) begin
            b = line_beats.pop_front();
            send_beat(b);
        end
        lines_sent++;
    endtask

    function automatic logic [7:0] b64_char(input int unsigned idx);
        if (idx < 26)
            return 8'(32'h41 + idx);
        else if (idx < 52)
            return 8'(32'h61 + idx - 32'd26);
        else if (idx < 62)
            return 8'(32'h30 + idx - 32'd52);
        else if (idx == 62)
            return ChPlus;
        return ChSlash;
    endfunction

    // a '/' is sent escaped half the time
    task automatic add_sextet(input int unsigned idx);
        if (idx == 63 && $urandom_range(0, 1) == 1)
            add_beat(ChBackslash, 1'b1);
        add_beat(b64_char(idx), 1'b1);
    endtask

    task automatic build_random_line();
        int unsigned quads;
        int unsigned pad;
        int unsigned n;
        int unsigned pick;
        if ($urandom_range(0, 3) != 0) begin
            quads = $urandom_range(0, 4);
            pad   = $urandom_range(0, 3);
            for (int q = 0; q < quads; q++) begin
                if ($urandom_range(0, 7) == 0)
                    add_beat(8'($urandom_range(0, 255)), 1'b0);
                for (int k = 0; k < 4; k++) begin
                    if (q == quads - 1 &&
                        ((pad == 1 && k == 3) || (pad == 2 && k >= 2) || (pad == 3 && k == 2)))
                        add_beat(PadChar, 1'b1);
                    else
                        add_sextet($urandom_range(0, 63));
                end
            end
            if ($urandom_range(0, 4) == 0)
                add_beat(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            // malformed: stray backslashes, padding anywhere, bytes outside the alphabet
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0:       add_beat(ChBackslash, 1'b1);
                    1:       add_beat(PadChar, 1'b1);
                    2:       add_beat(ChSlash, 1'b1);
                    3:       add_beat(8'($urandom_range(0, 255)), 1'b0);
                    4, 5:    add_sextet($urandom_range(0, 63));
                    default: add_beat(8'($urandom_range(0, 255)), 1'b1);
                endcase
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_text("az/9");
        send_line();
        add_text("+\\/9Zg==");
        send_line();
        // bad leading char, bare marker, double backslash, backslash left open at the end
        add_beat(8'hFF, 1'b1);
        add_text("AAA");
        add_beat(8'h00, 1'b0);
        add_text("\\\\");
        add_beat(8'h00, 1'b1);
        add_text("\\");
        send_line();
        add_beat(8'hA5, 1'b0);
        send_line();
        add_text("QQ");
        send_line();

        pause_until_drained();
        hold_request = 1'b1;

        while (beats_sent < BEAT_TARGET) begin
            if (!mid_hold_done && beats_sent >= 100) begin
                hold_request  = 1'b1;
                mid_hold_done = 1'b1;
            end
            if (!mid_drain_done && beats_sent >= 140) begin
                pause_until_drained();
                mid_drain_done = 1'b1;
            end
            quiet_tail = (beats_sent >= QUIET_FROM);
            build_random_line();
            send_line();
        end

        pause_until_drained();
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("Sent %0d char beats in %0d strings, checked %0d results.",
                 beats_sent, lines_sent, results_seen);
        $display("Mix: escaped and stray backslashes, padding, bad quads, bare markers, long stalls.");
        if (mismatches == 0)
            $display("PASS base64_decoder_with_slash_unescape");
        else
            $display("FAIL base64_decoder_with_slash_unescape");
        $finish;
    end

endmodule
